// ----- hdl/assert_macros.svh -----
// assertion macros shared by the draw engine rtl
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define FDE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/fde_pkg.sv -----
// shared types and constants of the framebuffer draw engine
// no dependencies
package fde_pkg;

  localparam int MaxWidthDef  = 512;
  localparam int MaxHeightDef = 512;

  localparam int CW  = 12;       // loop coordinate width, signed
  localparam int NW  = 44;       // divider numerator magnitude bits
  localparam int DW  = 29;       // divider denominator magnitude bits
  localparam int SW  = DW;       // slope width, signed q16
  localparam int PCW = NW + 1;   // generated pixel coordinate width, signed

  localparam logic [2:0] OpPixel   = 3'd0;
  localparam logic [2:0] OpFill    = 3'd1;
  localparam logic [2:0] OpOutline = 3'd2;
  localparam logic [2:0] OpLine    = 3'd3;
  localparam logic [2:0] OpReadClr = 3'd4;

  typedef struct packed {
    logic                  rc;   // read and clear instead of blend
    logic signed [PCW-1:0] x;
    logic signed [PCW-1:0] y;
  } px_req_t;

  typedef struct packed {
    logic        oob;            // pixel outside frame
    logic [23:0] rgb;            // red 23:16, green 15:8, blue 7:0
  } px_rsp_t;

endpackage

// ----- hdl/fde_div.sv -----
// iterative signed divider, quotient truncated toward zero, one bit per cycle
// depends on fde_pkg
module fde_div import fde_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW:0]   num_i,
  input  logic signed [DW:0]   den_i,
  output logic                 done_o,
  output logic signed [NW:0]   quo_o
);

  localparam int CntW = $clog2(NW + 1);

  logic            busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NW-1:0]   n_q, n_d;
  logic [DW:0]     r_q, r_d;
  logic [DW-1:0]   d_q, d_d;
  logic [DW:0]     rs;
  logic            fit;

  assign rs  = {r_q[DW-1:0], n_q[NW-1]};
  assign fit = rs >= {1'b0, d_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    n_d    = n_q;
    r_d    = r_q;
    d_d    = d_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = num_i[NW] ^ den_i[DW];
      n_d    = num_i[NW] ? NW'(-num_i) : NW'(num_i);
      d_d    = den_i[DW] ? DW'(-den_i) : DW'(den_i);
      r_d    = '0;
      cnt_d  = CntW'(NW);
    end else if (busy_q) begin
      r_d   = fit ? rs - {1'b0, d_q} : rs;
      n_d   = {n_q[NW-2:0], fit};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    n_q   <= n_d;
    r_q   <= r_d;
    d_q   <= d_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});

endmodule

// ----- hdl/fde_pixel_rmw.sv -----
// frame store with per-pixel read-modify-write blend and read-and-clear
// depends on fde_pkg; holds the frame memory and its clearing pass
module fde_pixel_rmw import fde_pkg::*; #(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [9:0]  eff_w_i,
  input  logic [9:0]  eff_h_i,
  input  logic [31:0] color_i,
  input  logic        req_valid_i,
  input  px_req_t     req_i,
  output logic        req_ready_o,
  output logic        rsp_done_o,
  output px_rsp_t     rsp_o,
  output logic        clearing_o
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [2:0] R_CLR  = 3'd0;
  localparam logic [2:0] R_IDLE = 3'd1;
  localparam logic [2:0] R_ADDR = 3'd2;
  localparam logic [2:0] R_READ = 3'd3;
  localparam logic [2:0] R_WR   = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d, addr_q, addr_d, waddr;
  logic          inf_q, inf_d, rc_q, rc_d, done_q, done_d;
  logic [9:0]    xl_q, xl_d, yl_q, yl_d;
  px_rsp_t       rsp_q, rsp_d;
  logic [23:0]   mem [Depth];
  logic [23:0]   rdata_q, wdata;
  logic          we, re, inframe;
  logic [19:0]   row_off;
  logic [20:0]   lin;

  function automatic logic [7:0] mix8(input logic [7:0] s, input logic [7:0] d,
                                      input logic [7:0] a);
    logic [15:0] v;
    logic [16:0] t;
    v = s * a + d * (8'd255 - a);
    // divide by 255 without a divider, exact below 2^16
    t = 17'(v) + 17'(v[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  assign inframe = !req_i.x[PCW-1] && !req_i.y[PCW-1]
                && (req_i.x < $signed(PCW'(eff_w_i)))
                && (req_i.y < $signed(PCW'(eff_h_i)));
  assign row_off = yl_q * eff_w_i;
  assign lin     = {1'b0, row_off} + 21'(xl_q);
  assign waddr   = (state_q == R_CLR) ? clr_q : addr_q;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    addr_d  = addr_q;
    inf_d   = inf_q;
    rc_d    = rc_q;
    xl_d    = xl_q;
    yl_d    = yl_q;
    rsp_d   = rsp_q;
    done_d  = 1'b0;
    we      = 1'b0;
    re      = 1'b0;
    wdata   = '0;
    case (state_q)
      R_CLR: begin
        we    = 1'b1;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(Depth - 1)) state_d = R_IDLE;
      end
      R_IDLE: begin
        if (req_valid_i) begin
          inf_d   = inframe;
          rc_d    = req_i.rc;
          xl_d    = req_i.x[9:0];
          yl_d    = req_i.y[9:0];
          state_d = R_ADDR;
        end
      end
      R_ADDR: begin
        if (!inf_q) begin
          rsp_d   = '{oob: 1'b1, rgb: 24'd0};
          done_d  = 1'b1;
          state_d = R_IDLE;
        end else begin
          addr_d  = AW'(lin);
          state_d = R_READ;
        end
      end
      R_READ: begin
        re      = 1'b1;
        state_d = R_WR;
      end
      R_WR: begin
        we = 1'b1;
        if (rc_q) begin
          wdata = '0;
          rsp_d = '{oob: 1'b0, rgb: rdata_q};
        end else begin
          wdata = {mix8(color_i[23:16], rdata_q[23:16], color_i[31:24]),
                   mix8(color_i[15:8],  rdata_q[15:8],  color_i[31:24]),
                   mix8(color_i[7:0],   rdata_q[7:0],   color_i[31:24])};
          rsp_d = '{oob: 1'b0, rgb: 24'd0};
        end
        done_d  = 1'b1;
        state_d = R_IDLE;
      end
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_CLR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    inf_q  <= inf_d;
    rc_q   <= rc_d;
    xl_q   <= xl_d;
    yl_q   <= yl_d;
    rsp_q  <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[addr_q];
  end

  assign req_ready_o = (state_q == R_IDLE);
  assign rsp_done_o  = done_q;
  assign rsp_o       = rsp_q;
  assign clearing_o  = (state_q == R_CLR);

endmodule

// ----- hdl/fde_walker.sv -----
// command sequencer: walks the pixels of each draw command and posts one result
// depends on fde_pkg and fde_div
module fde_walker import fde_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  logic [2:0]         op_i,
  input  logic [31:0]        color_i,
  input  logic signed [10:0] xs_i,
  input  logic signed [10:0] ys_i,
  input  logic signed [10:0] xe_i,
  input  logic signed [10:0] ye_i,
  input  logic [9:0]         w_i,
  input  logic [9:0]         h_i,
  input  logic [9:0]         eff_w_i,
  input  logic [9:0]         eff_h_i,
  input  logic               clearing_i,
  output logic [31:0]        color_o,
  output logic               req_valid_o,
  output px_req_t            req_o,
  input  logic               req_ready_i,
  input  logic               rsp_done_i,
  input  px_rsp_t            rsp_i,
  input  logic               out_free_i,
  output logic               res_valid_o,
  output px_rsp_t            res_o
);

  localparam logic [3:0] W_IDLE = 4'd0;
  localparam logic [3:0] W_REQ  = 4'd1;
  localparam logic [3:0] W_WAIT = 4'd2;
  localparam logic [3:0] W_FILL = 4'd3;
  localparam logic [3:0] W_OUTA = 4'd4;
  localparam logic [3:0] W_OUTB = 4'd5;
  localparam logic [3:0] W_VERT = 4'd6;
  localparam logic [3:0] W_SLW  = 4'd7;
  localparam logic [3:0] W_IC1  = 4'd8;
  localparam logic [3:0] W_IC2  = 4'd9;
  localparam logic [3:0] W_LXM  = 4'd10;
  localparam logic [3:0] W_LXC  = 4'd11;
  localparam logic [3:0] W_LYD  = 4'd12;
  localparam logic [3:0] W_LYW  = 4'd13;
  localparam logic [3:0] W_DONE = 4'd14;

  logic [3:0]            state_q, state_d, ret_q, ret_d;
  logic [2:0]            op_q, op_d;
  logic [31:0]           color_q, color_d;
  logic signed [CW-1:0]  xs_q, xs_d, ys_q, ys_d;
  logic [9:0]            w_q, w_d, h_q, h_d;
  logic signed [CW-1:0]  i_q, i_d, j_q, j_d, x0_q, x0_d, x1_q, x1_d, y1_q, y1_d;
  logic signed [CW-1:0]  k_q, k_d, sx_q, sx_d, ex_q, ex_d, sy_q, sy_d, ey_q, ey_d;
  logic                  sub_q, sub_d;
  logic signed [SW-1:0]  slope_q, slope_d;
  logic signed [SW+CW-1:0] prod_q, prod_d, mul;
  logic signed [CW-1:0]  mul_k;
  logic signed [PCW-1:0] icpt_q, icpt_d;
  px_req_t               req_q, req_d;
  logic                  status_q, status_d;
  logic [23:0]           rgb_q, rgb_d;
  logic                  div_start, div_done;
  logic signed [NW:0]    div_num, div_quo;
  logic signed [DW:0]    div_den;
  logic signed [CW-1:0]  cxs, cys, cxe, cye, cw, ch, fw, fh, xsum, ysum;
  logic signed [PCW-1:0] lsum;

  function automatic logic signed [PCW-1:0] shr16_t0(input logic signed [PCW-1:0] v);
    logic [PCW-1:0] mag, q;
    mag = v[PCW-1] ? PCW'(-v) : PCW'(v);
    q   = mag >> 16;
    return v[PCW-1] ? -$signed(q) : $signed(q);
  endfunction

  fde_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign cxs   = CW'(xs_i);
  assign cys   = CW'(ys_i);
  assign cxe   = CW'(xe_i);
  assign cye   = CW'(ye_i);
  assign cw    = $signed(CW'(w_i));
  assign ch    = $signed(CW'(h_i));
  assign fw    = $signed(CW'(eff_w_i));
  assign fh    = $signed(CW'(eff_h_i));
  assign xsum  = cxs + cw;
  assign ysum  = cys + ch;
  assign mul_k = (state_q == W_IC1) ? xs_q : k_q;
  assign mul   = slope_q * mul_k;
  assign lsum  = PCW'(prod_q) + icpt_q;

  always_comb begin
    state_d = state_q;  ret_d = ret_q;   op_d = op_q;     color_d = color_q;
    xs_d = xs_q;  ys_d = ys_q;  w_d = w_q;  h_d = h_q;
    i_d = i_q;  j_d = j_q;  x0_d = x0_q;  x1_d = x1_q;  y1_d = y1_q;
    k_d = k_q;  sx_d = sx_q;  ex_d = ex_q;  sy_d = sy_q;  ey_d = ey_q;
    sub_d = sub_q;  slope_d = slope_q;  prod_d = prod_q;  icpt_d = icpt_q;
    req_d = req_q;  status_d = status_q;  rgb_d = rgb_q;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    req_valid_o = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      W_IDLE: begin
        if (cmd_valid_i && !clearing_i) begin
          op_d = op_i;  color_d = color_i;  xs_d = cxs;  ys_d = cys;
          w_d = w_i;  h_d = h_i;  status_d = 1'b0;  rgb_d = '0;
          sx_d = (cxs < cxe) ? cxs : cxe;
          ex_d = (cxs < cxe) ? cxe : cxs;
          sy_d = (cys < cye) ? cys : cye;
          ey_d = (cys < cye) ? cye : cys;
          case (op_i)
            OpPixel, OpReadClr: begin
              req_d   = '{rc: (op_i == OpReadClr), x: PCW'(cxs), y: PCW'(cys)};
              ret_d   = W_DONE;
              state_d = W_REQ;
            end
            OpFill: begin
              x0_d    = cxs[CW-1] ? '0 : cxs;
              i_d     = cxs[CW-1] ? '0 : cxs;
              j_d     = cys[CW-1] ? '0 : cys;
              x1_d    = (xsum > fw) ? fw : xsum;
              y1_d    = (ysum > fh) ? fh : ysum;
              state_d = W_FILL;
            end
            OpOutline: begin
              i_d     = '0;
              sub_d   = 1'b0;
              state_d = (w_i == 10'd0 || h_i == 10'd0) ? W_DONE : W_OUTA;
            end
            OpLine: begin
              if (cxs == cxe) begin
                k_d     = (cys < cye) ? cys : cye;
                state_d = W_VERT;
              end else begin
                div_start = 1'b1;
                div_num   = (NW+1)'($signed({cys - cye, 16'h0000}));
                div_den   = (DW+1)'(cxs - cxe);
                state_d   = W_SLW;
              end
            end
            default: state_d = W_DONE;
          endcase
        end
      end
      W_REQ: begin
        req_valid_o = 1'b1;
        if (req_ready_i) state_d = W_WAIT;
      end
      W_WAIT: begin
        if (rsp_done_i) begin
          if (op_q == OpPixel || op_q == OpReadClr) status_d = rsp_i.oob;
          if (op_q == OpReadClr) rgb_d = rsp_i.rgb;
          state_d = ret_q;
        end
      end
      W_FILL: begin
        if (j_q >= y1_q) begin
          state_d = W_DONE;
        end else if (i_q >= x1_q) begin
          i_d = x0_q;
          j_d = j_q + CW'(1);
        end else begin
          req_d   = '{rc: 1'b0, x: PCW'(i_q), y: PCW'(j_q)};
          i_d     = i_q + CW'(1);
          ret_d   = W_FILL;
          state_d = W_REQ;
        end
      end
      W_OUTA: begin
        if (i_q == $signed(CW'(w_q))) begin
          i_d     = '0;
          sub_d   = 1'b0;
          state_d = W_OUTB;
        end else begin
          // top edge pixel, then the matching one on the bottom edge
          req_d   = '{rc: 1'b0, x: PCW'(xs_q + i_q),
                      y: PCW'(sub_q ? ys_q + $signed(CW'(h_q)) : ys_q)};
          sub_d   = !sub_q;
          if (sub_q) i_d = i_q + CW'(1);
          ret_d   = W_OUTA;
          state_d = W_REQ;
        end
      end
      W_OUTB: begin
        if (i_q == $signed(CW'(h_q))) begin
          state_d = W_DONE;
        end else begin
          req_d   = '{rc: 1'b0, x: PCW'(sub_q ? xs_q + $signed(CW'(w_q)) : xs_q),
                      y: PCW'(ys_q + i_q)};
          sub_d   = !sub_q;
          if (sub_q) i_d = i_q + CW'(1);
          ret_d   = W_OUTB;
          state_d = W_REQ;
        end
      end
      W_VERT: begin
        if (k_q >= ey_q) begin
          state_d = W_DONE;
        end else begin
          req_d   = '{rc: 1'b0, x: PCW'(xs_q), y: PCW'(k_q)};
          k_d     = k_q + CW'(1);
          ret_d   = W_VERT;
          state_d = W_REQ;
        end
      end
      W_SLW: begin
        if (div_done) begin
          slope_d = SW'(div_quo);
          state_d = W_IC1;
        end
      end
      W_IC1: begin
        prod_d  = mul;
        state_d = W_IC2;
      end
      W_IC2: begin
        icpt_d  = PCW'($signed({ys_q, 16'h0000})) - PCW'(prod_q);
        k_d     = sx_q;
        state_d = W_LXM;
      end
      W_LXM: begin
        if (k_q >= ex_q) begin
          k_d     = sy_q;
          state_d = (slope_q == '0) ? W_DONE : W_LYD;
        end else begin
          prod_d  = mul;
          state_d = W_LXC;
        end
      end
      W_LXC: begin
        req_d   = '{rc: 1'b0, x: PCW'(k_q), y: shr16_t0(lsum)};
        k_d     = k_q + CW'(1);
        ret_d   = W_LXM;
        state_d = W_REQ;
      end
      W_LYD: begin
        if (k_q >= ey_q) begin
          state_d = W_DONE;
        end else begin
          div_start = 1'b1;
          div_num   = (NW+1)'($signed({k_q, 16'h0000})) - icpt_q;
          div_den   = (DW+1)'(slope_q);
          state_d   = W_LYW;
        end
      end
      W_LYW: begin
        if (div_done) begin
          req_d   = '{rc: 1'b0, x: div_quo, y: PCW'(k_q)};
          k_d     = k_q + CW'(1);
          ret_d   = W_LYD;
          state_d = W_REQ;
        end
      end
      W_DONE: begin
        res_valid_o = out_free_i;
        if (out_free_i) state_d = W_IDLE;
      end
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q <= ret_d;  op_q <= op_d;  color_q <= color_d;
    xs_q <= xs_d;  ys_q <= ys_d;  w_q <= w_d;  h_q <= h_d;
    i_q <= i_d;  j_q <= j_d;  x0_q <= x0_d;  x1_q <= x1_d;  y1_q <= y1_d;
    k_q <= k_d;  sx_q <= sx_d;  ex_q <= ex_d;  sy_q <= sy_d;  ey_q <= ey_d;
    sub_q <= sub_d;  slope_q <= slope_d;  prod_q <= prod_d;  icpt_q <= icpt_d;
    req_q <= req_d;  status_q <= status_d;  rgb_q <= rgb_d;
  end

  assign cmd_ready_o = (state_q == W_IDLE) && !clearing_i;
  assign color_o     = color_q;
  assign req_o       = req_q;
  assign res_o       = '{oob: status_q, rgb: rgb_q};

endmodule

// ----- hdl/framebuffer_draw_engine_top.sv -----
// top level of the framebuffer draw engine: config registers, output register
// depends on fde_pkg, fde_walker, fde_pixel_rmw, assert_macros.svh
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+------------------------------------
//  command   | in  | s_axis_tvalid/tready   | s_axis_tdata, 104 bits
//  result    | out | m_axis_tvalid/tready   | m_axis_tdata, 32 bits
//  config    | in  | cfg_we_i (no wait)     | cfg_idx_i, cfg_data_i
//
// each pixel passes through the frame memory read-modify-write; a fill also
// spends a sequencer step at the end of each row, and a non-vertical line adds
// a divider run per pixel of its y pass and one slope division
// after reset a clearing pass writes zero to all MAX_WIDTH*MAX_HEIGHT entries,
// one per cycle; no command is taken meanwhile
// one command at a time; the next is taken while a result waits in the output
// register, and the sequencer stalls at its end until that register frees
module framebuffer_draw_engine_top import fde_pkg::*; #(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[2:0] color[34:3] x_start[45:35] y_start[56:46] x_end[67:57]
  // y_end[78:68] rect_width[88:79] rect_height[98:89], rest zero
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[0] red_out[8:1] green_out[16:9] blue_out[24:17], rest zero
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [9:0]   cfg_data_i
);

`include "assert_macros.svh"

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  logic [9:0]  fw_q, fh_q, eff_w, eff_h;
  logic        m_valid_q;
  logic [24:0] m_data_q;
  logic        s_fire, out_free, res_valid, req_valid, req_ready, rsp_done, clearing;
  logic [31:0] color;
  px_req_t     req;
  px_rsp_t     rsp, res;

  // register values beyond the store size clamp to it
  assign eff_w = (32'(fw_q) > 32'(MAX_WIDTH))  ? 10'(MAX_WIDTH)  : fw_q;
  assign eff_h = (32'(fh_q) > 32'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 10'd512;
      fh_q <= 10'd512;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWidth:  fw_q <= cfg_data_i;
        CfgHeight: fh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  fde_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .op_i        (s_axis_tdata[2:0]),
    .color_i     (s_axis_tdata[34:3]),
    .xs_i        ($signed(s_axis_tdata[45:35])),
    .ys_i        ($signed(s_axis_tdata[56:46])),
    .xe_i        ($signed(s_axis_tdata[67:57])),
    .ye_i        ($signed(s_axis_tdata[78:68])),
    .w_i         (s_axis_tdata[88:79]),
    .h_i         (s_axis_tdata[98:89]),
    .eff_w_i     (eff_w),
    .eff_h_i     (eff_h),
    .clearing_i  (clearing),
    .color_o     (color),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_ready_i (req_ready),
    .rsp_done_i  (rsp_done),
    .rsp_i       (rsp),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fde_pixel_rmw #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_rmw (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_w_i     (eff_w),
    .eff_h_i     (eff_h),
    .color_i     (color),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_ready_o (req_ready),
    .rsp_done_o  (rsp_done),
    .rsp_o       (rsp),
    .clearing_o  (clearing)
  );

  // output register, one transaction deep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) m_data_q <= {res.rgb[7:0], res.rgb[15:8], res.rgb[23:16], res.oob};
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_data_q};

  `FDE_ASSERT_NEXT(a_busy_after_accept, s_fire, !s_axis_tready, "accepted while busy")
  `FDE_ASSERT_IMP(a_no_overrun, res_valid, out_free, "result overwrote pending output")
  `FDE_ASSERT_IMP(a_oob_no_color, m_valid_q && m_data_q[0], m_data_q[24:1] == 24'd0,
                  "out of range result carries color")

endmodule
